/* sv/msga_pkg.sv */
// shared types and constants of the coarse-level scatter-add / gather block
package msga_pkg;

    localparam int COARSE_ENTRIES_DEF = 1024;
    localparam int INDEX_W            = 11;
    localparam int VALUE_W            = 32;
    localparam int SUM_W              = 40;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic sweep;
    } msga_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic op_read;
        logic op_clear_in;
        logic out_blocked;
    } msga_stat_t;

endpackage

/* sv/msga_req_if.sv */
// request channel: operation, coarse index and value
interface msga_req_if
    import msga_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [1:0]                operation;
    logic signed [INDEX_W-1:0] coarse_index;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output operation, output coarse_index, output value,
                    input ready);
    modport sink   (input valid, input operation, input coarse_index, input value,
                    output ready);
endinterface

/* sv/msga_rsp_if.sv */
// response channel: entry contents and sticky saturation flag
interface msga_rsp_if
    import msga_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] read_value;
    logic                    saturated;

    modport source (output valid, output read_value, output saturated, input ready);
    modport sink   (input valid, input read_value, input saturated, output ready);
endinterface

/* sv/multigrid_scatter_add_gather.sv */
// top level of the coarse-level scatter-add / gather block
//
// req carries one operation per transaction: clear all, add a Q15.16 value into
// a coarse entry, write an entry, or read an entry. Only read produces a
// transaction on rsp, carrying the Q23.16 entry contents (zero if cleared or
// out of range) and the sticky saturation flag.
// add, write and read are accepted in the idle state, which reads the entry
// memory into a register; the execute state runs the saturating add and
// writes back, or loads the output register that drives rsp for a read.
// clear is accepted and then sweeps the valid bits, which live in the entry
// memory, one entry per cycle through its single write port.
// after reset the same sweep runs over every entry with req.ready low.
// rsp has an output register: while a result waits, adds and writes go on;
// a further read holds in its execute cycle until rsp is taken.
module multigrid_scatter_add_gather
    import msga_pkg::*;
#(
    parameter int COARSE_ENTRIES = COARSE_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    msga_req_if.sink   req,
    msga_rsp_if.source rsp
);

    msga_cmd_t  cmd;
    msga_stat_t stat;

    msga_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    msga_datapath #(
        .COARSE_ENTRIES (COARSE_ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_operation  (req.operation),
        .req_index      (req.coarse_index),
        .req_value      (req.value),
        .rsp_valid      (rsp.valid),
        .rsp_ready      (rsp.ready),
        .rsp_read_value (rsp.read_value),
        .rsp_saturated  (rsp.saturated)
    );

endmodule

/* sv/msga_datapath.sv */
// datapath: coarse sum memory, saturating adder, sticky flag, sweep counter, output register
module msga_datapath
    import msga_pkg::*;
#(
    parameter int COARSE_ENTRIES = COARSE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  msga_cmd_t                 cmd,
    output msga_stat_t                stat,
    input  logic [1:0]                req_operation,
    input  logic signed [INDEX_W-1:0] req_index,
    input  logic signed [VALUE_W-1:0] req_value,
    output logic                      rsp_valid,
    input  logic                      rsp_ready,
    output logic signed [SUM_W-1:0]   rsp_read_value,
    output logic                      rsp_saturated
);

    localparam int AW = $clog2(COARSE_ENTRIES);
    localparam int WW = INDEX_W - 1 + AW;
    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // entry word: valid bit on top of the sum
    logic [SUM_W:0] mem [COARSE_ENTRIES];

    op_t                 op_reg;
    logic                in_range_reg;
    logic [AW-1:0]       addr_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [SUM_W:0]      rd_reg;
    logic                sticky_reg;
    logic [AW-1:0]       sweep_cnt_reg;
    logic                out_valid_reg;
    logic [SUM_W-1:0]    out_value_reg;
    logic                out_sat_reg;

    logic                in_range;
    logic [WW-1:0]       idx_wide;
    logic [AW-1:0]       in_addr;
    logic                sweep_last;
    logic [SUM_W-1:0]    base;
    logic [SUM_W:0]      sum_ext;
    logic                ovf;
    logic [SUM_W-1:0]    sat_sum;
    logic [SUM_W-1:0]    value_ext;
    logic [SUM_W-1:0]    wr_sum;
    logic                mem_we;

    assign in_range = !req_index[INDEX_W-1]
                      && (32'(req_index[INDEX_W-2:0]) < 32'(COARSE_ENTRIES));
    assign idx_wide = {{AW{1'b0}}, req_index[INDEX_W-2:0]};
    assign in_addr  = idx_wide[AW-1:0];
    assign sweep_last = (sweep_cnt_reg == AW'(COARSE_ENTRIES - 1));

    // invalid entry counts as zero
    assign base      = rd_reg[SUM_W] ? rd_reg[SUM_W-1:0] : '0;
    assign value_ext = {{(SUM_W-VALUE_W){value_reg[VALUE_W-1]}}, value_reg};
    assign sum_ext   = {base[SUM_W-1], base} + {value_ext[SUM_W-1], value_ext};
    assign ovf       = sum_ext[SUM_W] ^ sum_ext[SUM_W-1];
    assign sat_sum   = ovf ? (sum_ext[SUM_W] ? SUM_MIN : SUM_MAX) : sum_ext[SUM_W-1:0];
    assign wr_sum    = (op_reg == OP_ADD) ? sat_sum : value_ext;
    assign mem_we    = cmd.exec && in_range_reg
                       && ((op_reg == OP_ADD) || (op_reg == OP_WRITE));

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            mem[sweep_cnt_reg] <= '0;
        end
        else if (mem_we)
        begin
            mem[addr_reg] <= {1'b1, wr_sum};
        end
        if (cmd.capture)
        begin
            rd_reg <= mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= op_t'(req_operation);
            in_range_reg <= in_range;
            addr_reg     <= in_addr;
            value_reg    <= req_value;
        end
        if (cmd.exec && (op_reg == OP_READ))
        begin
            out_value_reg <= (in_range_reg && rd_reg[SUM_W]) ? rd_reg[SUM_W-1:0] : '0;
            out_sat_reg   <= sticky_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg    <= 1'b0;
            sweep_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture && (op_t'(req_operation) == OP_CLEAR))
            begin
                sticky_reg <= 1'b0;
            end
            else if (mem_we && (op_reg == OP_ADD) && ovf)
            begin
                sticky_reg <= 1'b1;
            end
            if (cmd.sweep)
            begin
                sweep_cnt_reg <= sweep_last ? '0 : sweep_cnt_reg + 1'b1;
            end
            if (cmd.exec && (op_reg == OP_READ))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.sweep_last  = sweep_last;
    assign stat.op_read     = (op_reg == OP_READ);
    assign stat.op_clear_in = (op_t'(req_operation) == OP_CLEAR);
    assign stat.out_blocked = out_valid_reg && !rsp_ready;

    assign rsp_valid      = out_valid_reg;
    assign rsp_read_value = out_value_reg;
    assign rsp_saturated  = out_sat_reg;

endmodule

/* sv/msga_ctrl.sv */
// controller: sweep after reset and clear, accept, execute
module msga_ctrl
    import msga_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  msga_stat_t stat,
    output msga_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_ready   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.sweep   = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = stat.op_clear_in ? ST_SWEEP : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // a read waits until the output register can take it
                if (!(stat.op_read && stat.out_blocked))
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

endmodule

/* verif/multigrid_scatter_add_gather_test.sv */
// self-checking testbench of the coarse-level scatter-add / gather block
module multigrid_scatter_add_gather_test;
    import msga_pkg::*;

    localparam int     ENTRIES    = COARSE_ENTRIES_DEF;
    localparam int     TOTAL_REQS = 1400;
    localparam longint SUM_MAX    = 64'sd549755813887;
    localparam longint SUM_MIN    = -SUM_MAX - 64'sd1;

    typedef struct {
        op_t                       op;
        logic signed [INDEX_W-1:0] index;
        logic signed [VALUE_W-1:0] value;
    } coarse_req_t;

    typedef struct {
        logic signed [SUM_W-1:0] read_value;
        logic                    saturated;
    } entry_readout_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msga_req_if req_ch ();
    msga_rsp_if rsp_ch ();

    multigrid_scatter_add_gather #(
        .COARSE_ENTRIES(ENTRIES)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // mirror of the coarse vector
    logic signed [SUM_W-1:0] coarse_sum_mirror [ENTRIES];
    bit                      entry_live        [ENTRIES];
    bit                      sticky_mirror;

    coarse_req_t    request_backlog[$];
    entry_readout_t read_results_due[$];
    coarse_req_t    driven_req;

    int mismatches    = 0;
    int accepted_reqs = 0;
    int req_gap_left  = 0;
    int gap_next;
    int rsp_stall_left = 0;
    int stall_next;
    bit sender_burst   = 1'b0;
    bit receiver_burst = 1'b0;
    bit rsp_hold_on    = 1'b0;
    bit rsp_hold_done  = 1'b0;
    int rsp_hold_left  = 0;

    // stimulus bookkeeping: entries that have been stored to at least once
    int hot_entries[8] = '{0, 1, 2, 3, 341, 682, 1022, 1023};
    int spare_entries[$];
    int sat_runs = 0;

    task automatic flag_mismatch(input string what);
        if (mismatches < 50)
            $display("mismatch at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void apply_to_coarse_vector(input coarse_req_t it);
        longint         sum;
        int             idx;
        bit             in_range;
        entry_readout_t res;
        idx      = int'(it.index);
        in_range = (idx >= 0) && (idx < ENTRIES);
        case (it.op)
            OP_CLEAR:
            begin
                foreach (entry_live[i])
                    entry_live[i] = 1'b0;
                sticky_mirror = 1'b0;
            end
            OP_ADD:
                if (in_range)
                begin
                    sum = entry_live[idx] ? longint'(coarse_sum_mirror[idx]) : 64'sd0;
                    sum = sum + longint'(it.value);
                    if (sum > SUM_MAX)
                    begin
                        sum           = SUM_MAX;
                        sticky_mirror = 1'b1;
                    end
                    else if (sum < SUM_MIN)
                    begin
                        sum           = SUM_MIN;
                        sticky_mirror = 1'b1;
                    end
                    coarse_sum_mirror[idx] = sum[SUM_W-1:0];
                    entry_live[idx]        = 1'b1;
                end
            OP_WRITE:
                if (in_range)
                begin
                    coarse_sum_mirror[idx] = SUM_W'(it.value);
                    entry_live[idx]        = 1'b1;
                end
            default:
            begin
                res.read_value = (in_range && entry_live[idx]) ? coarse_sum_mirror[idx] : '0;
                res.saturated  = sticky_mirror;
                read_results_due.push_back(res);
            end
        endcase
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic void push_req(input op_t op, input int index, input logic [31:0] value);
        coarse_req_t it;
        it.op    = op;
        it.index = INDEX_W'(index);
        it.value = value;
        request_backlog.push_back(it);
    endfunction

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return 32'($urandom_range(0, 1 << 17)) - 32'h0001_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic int skip_index();
        return -int'($urandom_range(1, 1024));
    endfunction

    // index for add and read: only entries already stored to, or skipped ones
    function automatic int live_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return skip_index();
        if (r < 30 && spare_entries.size() > 0)
            return spare_entries[$urandom_range(0, spare_entries.size() - 1)];
        return hot_entries[$urandom_range(0, 7)];
    endfunction

    function automatic int write_index();
        int r;
        int u;
        r = $urandom_range(0, 99);
        if (r < 10)
            return skip_index();
        if (r < 50)
        begin
            u = $urandom_range(0, ENTRIES - 1);
            if (spare_entries.size() < 64)
                spare_entries.push_back(u);
            return u;
        end
        return hot_entries[$urandom_range(0, 7)];
    endfunction

    // long run of near-extreme adds to one entry, driving it into the clamp
    function automatic void queue_saturation_run(input bit upward, input int entry);
        logic [31:0] step;
        push_req(OP_WRITE, entry, upward ? 32'h7FFF_FFFF : 32'h8000_0000);
        for (int k = 0; k < 265; k++)
        begin
            step = (upward ? 32'h7FF0_0000 : 32'h8000_0000) + 32'($urandom_range(0, 20'hFFFFF));
            push_req(OP_ADD, entry, step);
            if ($urandom_range(0, 31) == 0)
                push_req(OP_READ, entry, $urandom());
        end
        push_req(OP_ADD, entry, upward ? 32'h8000_0000 : 32'h7FFF_FFFF);
        push_req(OP_READ, entry, $urandom());
        push_req(OP_READ, hot_entries[$urandom_range(0, 7)], $urandom());
        push_req(OP_CLEAR, skip_index(), $urandom());
        push_req(OP_READ, entry, $urandom());
    endfunction

    function automatic void queue_random_req();
        int r;
        r = $urandom_range(0, 199);
        if (r < 3)
            push_req(OP_CLEAR, $urandom_range(0, 2047) - 1024, $urandom());
        else if (r < 100)
            push_req(OP_ADD, live_index(), draw_value());
        else if (r < 130)
            push_req(OP_WRITE, write_index(), draw_value());
        else
            push_req(OP_READ, live_index(), $urandom());
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_gap_left <= 0;
        end
        else
        begin
            gap_next = req_gap_left;
            if (req_ch.valid && req_ch.ready)
            begin
                apply_to_coarse_vector(driven_req);
                accepted_reqs <= accepted_reqs + 1;
                gap_next = draw_wait(sender_burst);
                if ($urandom_range(0, 39) == 0)
                    sender_burst <= !sender_burst;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (gap_next == 0 && request_backlog.size() > 0)
                begin
                    driven_req          = request_backlog.pop_front();
                    req_ch.operation    <= driven_req.op;
                    req_ch.coarse_index <= driven_req.index;
                    req_ch.value        <= driven_req.value;
                    req_ch.valid        <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    if (gap_next > 0)
                        gap_next--;
                end
            end
            req_gap_left <= gap_next;
        end
    end

    // long hold-off on the response side so the block backs up into req
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_hold_on   <= 1'b0;
            rsp_hold_done <= 1'b0;
            rsp_hold_left <= 0;
        end
        else if (!rsp_hold_done && accepted_reqs >= 300)
        begin
            rsp_hold_on   <= 1'b1;
            rsp_hold_done <= 1'b1;
            rsp_hold_left <= 300;
        end
        else if (rsp_hold_left > 0)
        begin
            rsp_hold_left <= rsp_hold_left - 1;
            if (rsp_hold_left == 1)
                rsp_hold_on <= 1'b0;
        end
    end

    // response monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready   <= 1'b0;
            rsp_stall_left <= 0;
        end
        else
        begin
            stall_next = rsp_stall_left;
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (read_results_due.size() == 0)
                    flag_mismatch($sformatf("read transaction with none due, value %0h",
                                            rsp_ch.read_value));
                else
                begin
                    entry_readout_t due;
                    due = read_results_due.pop_front();
                    if (rsp_ch.read_value !== due.read_value)
                        flag_mismatch($sformatf("read_value %0h, want %0h",
                                                rsp_ch.read_value, due.read_value));
                    if (rsp_ch.saturated !== due.saturated)
                        flag_mismatch($sformatf("saturated %0b, want %0b",
                                                rsp_ch.saturated, due.saturated));
                end
                stall_next = draw_wait(receiver_burst);
                if ($urandom_range(0, 29) == 0)
                    receiver_burst <= !receiver_burst;
            end
            else if (stall_next > 0)
                stall_next--;
            rsp_stall_left <= stall_next;
            rsp_ch.ready   <= (stall_next == 0) && !rsp_hold_on;
        end
    end

    initial
    begin
        // directed: extremes, skipped indexes, clear, add to a dropped entry
        push_req(OP_WRITE, 0, 32'h7FFF_FFFF);
        push_req(OP_WRITE, 1, 32'h8000_0000);
        push_req(OP_WRITE, 2, 32'h0);
        push_req(OP_WRITE, 3, 32'hFFFF_FFFF);
        push_req(OP_WRITE, 341, 32'h0001_0000);
        push_req(OP_WRITE, 682, 32'hFFFF_0000);
        push_req(OP_WRITE, 1022, 32'h1234_5678);
        push_req(OP_WRITE, 1023, 32'hEDCB_A988);
        push_req(OP_READ, 0, 32'h0);
        push_req(OP_READ, 1023, 32'hFFFF_FFFF);
        push_req(OP_ADD, 0, 32'h7FFF_FFFF);
        push_req(OP_ADD, 1, 32'h8000_0000);
        push_req(OP_ADD, -1, 32'h0000_0005);
        push_req(OP_ADD, -1024, 32'h7FFF_FFFF);
        push_req(OP_WRITE, -1, 32'h5555_5555);
        push_req(OP_READ, -1, 32'h0);
        push_req(OP_READ, -1024, 32'h0);
        push_req(OP_READ, 0, 32'h0);
        push_req(OP_READ, 1, 32'h0);
        push_req(OP_CLEAR, 0, 32'h0);
        push_req(OP_READ, 0, 32'h0);
        push_req(OP_ADD, 2, 32'hAAAA_AAAA);
        push_req(OP_ADD, 2, 32'h5555_5555);
        push_req(OP_READ, 2, 32'h0);
        push_req(OP_READ, 341, 32'h0);

        while (request_backlog.size() < TOTAL_REQS)
        begin
            if ((sat_runs == 0 && request_backlog.size() >= 200) ||
                (sat_runs == 1 && request_backlog.size() >= 700) ||
                (sat_runs == 2 && $urandom_range(0, 299) == 0))
            begin
                queue_saturation_run(sat_runs != 1 ? $urandom_range(0, 1) == 1 : 1'b0,
                                     hot_entries[$urandom_range(0, 7)]);
                sat_runs++;
            end
            else
                queue_random_req();
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (request_backlog.size() > 0 || req_ch.valid)
            @(posedge clk);
        while (read_results_due.size() > 0)
            @(posedge clk);
        // a trailing clear may still be sweeping
        repeat (ENTRIES + 64) @(posedge clk);

        if (mismatches == 0 && read_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* multigrid_scatter_add_gather.f */
sv/msga_pkg.sv
sv/msga_req_if.sv
sv/msga_rsp_if.sv
sv/msga_datapath.sv
sv/msga_ctrl.sv
sv/multigrid_scatter_add_gather.sv
verif/multigrid_scatter_add_gather_test.sv
